FILE: src/u8n1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 package
// Shared widths, reset values and register addresses for the 8N1
// transmitter and receiver.
// ----------------------------------------------------------------------------
package u8n1_pkg;

	// Default width of the bit period timers.
	localparam int unsigned TIMER_BITS_DEF = 16;

	// Width of the configuration register holding the bit period.
	localparam int unsigned CPB_BITS = 16;

	// Bit period after reset, in ticks (accepted input words).
	localparam logic [CPB_BITS-1:0] CPB_RESET = 16'd6076;

	// Frame layout: start bit, eight data bits, stop bit.
	localparam int unsigned DATA_BITS  = 8;
	localparam int unsigned FRAME_BITS = 10;

	// Bit counter states of the receiver and transmitter.
	localparam logic [3:0] RX_CNT_START  = 4'd0;
	localparam logic [3:0] RX_CNT_D_LAST = 4'd8;
	localparam logic [3:0] RX_CNT_STOP   = 4'd9;
	localparam logic [3:0] TX_CNT_LAST   = 4'd9;
	localparam logic [3:0] TX_CNT_DONE   = 4'd10;

	// APB address map.
	localparam int unsigned APB_ADDR_BITS = 2;
	localparam int unsigned APB_DATA_BITS = 32;
	localparam logic [APB_ADDR_BITS-1:0] ADDR_CYCLES_PER_BIT = 2'd0;

	typedef logic [DATA_BITS-1:0]  byte_t;
	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [3:0]            bit_cnt_t;

endpackage

FILE: src/u8n1_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 channel interfaces
// Valid/ready channels for the per-tick input word and the per-tick result
// word of the 8N1 transceiver.
// ----------------------------------------------------------------------------

// Input word: one clock tick of serial line timing.
interface u8n1_in_if;
	logic             valid;
	logic             ready;
	logic             rx_line;
	logic             send;
	u8n1_pkg::byte_t  send_byte;

	modport source (output valid, output rx_line, output send, output send_byte,
		input ready);
	modport sink (input valid, input rx_line, input send, input send_byte,
		output ready);
endinterface

// Result word: line levels and strobes for the same tick.
interface u8n1_out_if;
	logic             valid;
	logic             ready;
	logic             tx_line;
	logic             rx_valid;
	u8n1_pkg::byte_t  rx_byte;
	logic             tx_busy;

	modport source (output valid, output tx_line, output rx_valid, output rx_byte,
		output tx_busy, input ready);
	modport sink (input valid, input tx_line, input rx_valid, input rx_byte,
		input tx_busy, output ready);
endinterface

FILE: src/uart_8n1_transceiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver
// Serial 8N1 receiver and transmitter, advanced by one input word per tick.
// ----------------------------------------------------------------------------
// Each input word is one tick of serial line time: the sampled receive level
// and an optional byte to send. Each accepted word yields exactly one result
// word with the transmit level, a received-byte strobe with its byte, and a
// transmitter busy flag. The block takes one word per cycle while the result
// channel is free. Path: one input register, one result register, with the
// receiver and transmitter state updated in the single pass between them. The
// receiver starts on a low line, samples data LSB first at mid bit and reports
// the byte at mid stop bit without checking it. The transmitter sends start,
// eight data bits LSB first and stop; send requests while busy are dropped.
// The bit period in ticks is the cycles_per_bit register at APB address 0
// (reset 6076), clamped to what a TIMER_BITS counter holds. Write it only
// while no words are in flight.
module uart_8n1_transceiver #(
	parameter int unsigned TIMER_BITS = u8n1_pkg::TIMER_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	u8n1_in_if.sink                                in_ch,
	u8n1_out_if.source                             out_ch,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [u8n1_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [u8n1_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [u8n1_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                   pready
);

	localparam int unsigned CmpW = (TIMER_BITS > u8n1_pkg::CPB_BITS) ?
		TIMER_BITS : u8n1_pkg::CPB_BITS;

	// Configuration register.
	logic [u8n1_pkg::CPB_BITS-1:0] cpb_q;

	// Input stage.
	logic             valid_s1;
	logic             rx_line_s1;
	logic             send_s1;
	u8n1_pkg::byte_t  send_byte_s1;

	// Result stage.
	logic             valid_s2;
	logic             tx_line_s2;
	logic             rx_valid_s2;
	u8n1_pkg::byte_t  rx_byte_s2;
	logic             tx_busy_s2;

	// Receiver and transmitter state.
	logic                   rx_active_q;
	logic [TIMER_BITS-1:0]  rx_timer_q;
	u8n1_pkg::bit_cnt_t     rx_cnt_q;
	u8n1_pkg::byte_t        rx_shift_q;
	logic                   tx_active_q;
	logic [TIMER_BITS-1:0]  tx_timer_q;
	u8n1_pkg::bit_cnt_t     tx_cnt_q;
	u8n1_pkg::frame_t       tx_frame_q;

	// Next state from the step logic.
	logic                   rx_active_d;
	logic [TIMER_BITS-1:0]  rx_timer_d;
	u8n1_pkg::bit_cnt_t     rx_cnt_d;
	u8n1_pkg::byte_t        rx_shift_d;
	logic                   rx_valid_d;
	u8n1_pkg::byte_t        rx_byte_d;
	logic                   tx_active_d;
	logic [TIMER_BITS-1:0]  tx_timer_d;
	u8n1_pkg::bit_cnt_t     tx_cnt_d;
	u8n1_pkg::frame_t       tx_frame_d;

	logic                   advance;
	logic                   cfg_wr;
	logic [CmpW-1:0]        cpb_ext;
	logic [CmpW-1:0]        mask_ext;
	logic [TIMER_BITS-1:0]  period;

	// Handshake: the input stage moves whenever the result register is free.
	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	// APB register access.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == u8n1_pkg::ADDR_CYCLES_PER_BIT);
	assign prdata = (paddr == u8n1_pkg::ADDR_CYCLES_PER_BIT) ?
		u8n1_pkg::APB_DATA_BITS'(cpb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= u8n1_pkg::CPB_RESET;
		end else if (cfg_wr) begin
			cpb_q <= pwdata[u8n1_pkg::CPB_BITS-1:0];
		end
	end

	// Bit period, clamped to the timer range.
	assign cpb_ext  = CmpW'(cpb_q);
	assign mask_ext = CmpW'({TIMER_BITS{1'b1}});
	assign period   = (cpb_ext > mask_ext) ? TIMER_BITS'(mask_ext) : TIMER_BITS'(cpb_ext);

	// Receiver step.
	always_comb begin
		logic [TIMER_BITS-1:0] tmr_inc;
		logic [TIMER_BITS-1:0] target;
		rx_active_d = rx_active_q;
		rx_timer_d  = rx_timer_q;
		rx_cnt_d    = rx_cnt_q;
		rx_shift_d  = rx_shift_q;
		rx_valid_d  = 1'b0;
		rx_byte_d   = '0;
		tmr_inc     = rx_timer_q + 1'b1;
		target      = (rx_cnt_q == u8n1_pkg::RX_CNT_START) ? (period >> 1) : period;
		if (!rx_active_q) begin
			if (!rx_line_s1) begin
				rx_active_d = 1'b1;
				rx_timer_d  = '0;
				rx_cnt_d    = u8n1_pkg::RX_CNT_START;
			end
		end else begin
			rx_timer_d = tmr_inc;
			if (tmr_inc >= target) begin
				rx_timer_d = '0;
				rx_cnt_d   = rx_cnt_q + 1'b1;
				if (rx_cnt_q >= u8n1_pkg::RX_CNT_STOP) begin
					// Mid stop bit: hand the byte out and go idle.
					rx_valid_d  = 1'b1;
					rx_byte_d   = rx_shift_q;
					rx_active_d = 1'b0;
					rx_cnt_d    = u8n1_pkg::RX_CNT_START;
				end else if (rx_cnt_q != u8n1_pkg::RX_CNT_START) begin
					rx_shift_d = {rx_line_s1, rx_shift_q[u8n1_pkg::DATA_BITS-1:1]};
				end
			end
		end
	end

	// Transmitter step: advance a running frame, then take a new byte if idle.
	always_comb begin
		logic [TIMER_BITS-1:0] tmr_inc;
		u8n1_pkg::bit_cnt_t    cnt_inc;
		tx_active_d = tx_active_q;
		tx_timer_d  = tx_timer_q;
		tx_cnt_d    = tx_cnt_q;
		tx_frame_d  = tx_frame_q;
		tmr_inc     = tx_timer_q + 1'b1;
		cnt_inc     = tx_cnt_q + 1'b1;
		if (tx_active_q) begin
			tx_timer_d = tmr_inc;
			if (tmr_inc >= period) begin
				tx_timer_d = '0;
				tx_frame_d = {1'b1, tx_frame_q[u8n1_pkg::FRAME_BITS-1:1]};
				tx_cnt_d   = cnt_inc;
				if (cnt_inc >= u8n1_pkg::TX_CNT_DONE) begin
					tx_active_d = 1'b0;
					tx_cnt_d    = '0;
					tx_frame_d  = '1;
				end
			end
		end
		if (!tx_active_d && send_s1) begin
			tx_active_d = 1'b1;
			tx_timer_d  = '0;
			tx_cnt_d    = '0;
			tx_frame_d  = {1'b1, send_byte_s1, 1'b0};
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rx_line_s1   <= in_ch.rx_line;
			send_s1      <= in_ch.send;
			send_byte_s1 <= in_ch.send_byte;
		end
	end

	// Line state, committed once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_active_q <= 1'b0;
			rx_timer_q  <= '0;
			rx_cnt_q    <= '0;
			rx_shift_q  <= '0;
			tx_active_q <= 1'b0;
			tx_timer_q  <= '0;
			tx_cnt_q    <= '0;
			tx_frame_q  <= '1;
		end else if (advance) begin
			rx_active_q <= rx_active_d;
			rx_timer_q  <= rx_timer_d;
			rx_cnt_q    <= rx_cnt_d;
			rx_shift_q  <= rx_shift_d;
			tx_active_q <= tx_active_d;
			tx_timer_q  <= tx_timer_d;
			tx_cnt_q    <= tx_cnt_d;
			tx_frame_q  <= tx_frame_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			tx_line_s2  <= tx_frame_d[0];
			rx_valid_s2 <= rx_valid_d;
			rx_byte_s2  <= rx_byte_d;
			tx_busy_s2  <= tx_active_d;
		end
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.tx_line  = tx_line_s2;
	assign out_ch.rx_valid = rx_valid_s2;
	assign out_ch.rx_byte  = rx_byte_s2;
	assign out_ch.tx_busy  = tx_busy_s2;

	// An idle transmitter always holds the line high.
	a_tx_idle_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_active_q |-> (tx_frame_q == '1))
		else $error("idle transmitter frame not all ones");

	// Bit counters never run past the stop bit.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_cnt_q <= u8n1_pkg::RX_CNT_STOP) && (tx_cnt_q <= u8n1_pkg::TX_CNT_LAST))
		else $error("bit counter out of range");

	// The received byte reads zero on ticks without a strobe.
	a_rx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rx_valid_s2) |-> (rx_byte_s2 == '0))
		else $error("rx_byte nonzero without rx_valid");

	// An accepted word always occupies the input stage on the next cycle.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> valid_s1)
		else $error("accepted word lost");

	// A received byte is reported only while the receiver is at the stop bit of a frame.
	a_rx_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rx_valid_d) |-> (rx_active_q && (rx_cnt_q == u8n1_pkg::RX_CNT_STOP)))
		else $error("rx strobe outside stop bit");

endmodule
